// ----- hw/rtl/ovl_pkg.sv -----
// Shared types and constants for the ordered value list.
// Holds the request and status codes, the state encoding and the control
// struct sent to each storage cell. No dependencies.
`timescale 1ns / 1ps

package ovl_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned ValueW  = 32;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned CountW  = 5;

  // Default number of list entries.
  localparam int unsigned ListDepth = 16;

  // Request codes. The unused code is handled as a search.
  typedef enum logic [ReqW-1:0] {
    REQ_APPEND = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2
  } req_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STS_APPENDED  = 3'd0,
    STS_DELETED   = 3'd1,
    STS_FOUND     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_EMPTY     = 3'd4,
    STS_FULL      = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic              append_go;
    logic              delete_go;
    logic [ValueW-1:0] key;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/ordered_value_list.sv -----
// Top level of the ordered value list: a chain of storage cells and the
// request controller with its result register. Depends on ovl_pkg, ovl_cell.
// ---------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  request   in_valid_i / in_ready_o   req_type_i, item_value_i
//  result    out_valid_o / out_ready_i status_o, position_o, entry_count_o
//
// An item is captured into the request registers; in the execute state all cells
// compare against the key in parallel and a delete shifts the cells from the
// match on by one place. One item is in work at a time; the result register is
// loaded in the execute state and the next item is taken once it is free or drained.
// A stalled result holds its value and blocks new items until it is taken.
// Reset clears the fill count and the control state; entries are not reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_value_list #(
  parameter int unsigned LIST_DEPTH = ovl_pkg::ListDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ovl_pkg::ReqW-1:0]      req_type_i,
  input  logic signed [ovl_pkg::ValueW-1:0] item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ovl_pkg::StatusW-1:0]   status_o,
  output logic [ovl_pkg::PosW-1:0]      position_o,
  output logic [ovl_pkg::CountW-1:0]    entry_count_o
);

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(LIST_DEPTH);

  ovl_pkg::state_e            state_q, state_d;
  logic [ovl_pkg::ReqW-1:0]   req_q;
  logic [ovl_pkg::ValueW-1:0] key_q;
  logic [CntW-1:0]            count_q, count_d;
  logic                       out_valid_q, out_valid_d;
  ovl_pkg::status_e           status_q, status_d;
  logic [CntW-1:0]            pos_q, pos_d;

  ovl_pkg::cell_ctrl_t        ctrl;
  logic [ovl_pkg::ValueW-1:0] cell_value [LIST_DEPTH];
  logic [LIST_DEPTH:0]        match_chain;
  logic [LIST_DEPTH-1:0]      first_hit;
  logic                       found;
  logic [CntW-1:0]            hit_pos;
  logic                       in_accept;

  assign in_accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ovl_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);

  // Chain of cells, oldest entry in cell 0.
  assign match_chain[0] = 1'b0;
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] IdxC = CntW'(i);
    logic [ovl_pkg::ValueW-1:0] next_value;

    if (i == LIST_DEPTH - 1) begin : g_last
      assign next_value = cell_value[i];
    end else begin : g_mid
      assign next_value = cell_value[i+1];
    end

    ovl_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occupied_i     (IdxC < count_q),
      .tail_i         (IdxC == count_q),
      .match_before_i (match_chain[i]),
      .next_value_i   (next_value),
      .value_o        (cell_value[i]),
      .match_before_o (match_chain[i+1]),
      .first_hit_o    (first_hit[i])
    );
  end

  assign found = match_chain[LIST_DEPTH];

  // Encode the one-hot first match into a 1-based position.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (first_hit[i]) begin
        hit_pos = hit_pos | CntW'(i + 1);
      end
    end
  end

  // Capture the request when it is accepted.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= req_type_i;
      key_q <= item_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ovl_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ovl_pkg::ST_EXEC) begin
      status_q <= status_d;
      pos_q    <= pos_d;
    end
  end

  // Next state, cell control and result.
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    status_d       = ovl_pkg::STS_NOT_FOUND;
    pos_d          = '0;
    ctrl.append_go = 1'b0;
    ctrl.delete_go = 1'b0;
    ctrl.key       = key_q;
    unique case (state_q)
      ovl_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = ovl_pkg::ST_EXEC;
        end
      end
      ovl_pkg::ST_EXEC: begin
        state_d     = ovl_pkg::ST_IDLE;
        out_valid_d = 1'b1;
        unique case (req_q)
          ovl_pkg::REQ_APPEND: begin
            if (count_q == DepthC) begin
              status_d = ovl_pkg::STS_FULL;
            end else begin
              status_d       = ovl_pkg::STS_APPENDED;
              ctrl.append_go = 1'b1;
              count_d        = count_q + CntW'(1);
            end
          end
          ovl_pkg::REQ_DELETE: begin
            if (count_q == '0) begin
              status_d = ovl_pkg::STS_EMPTY;
            end else if (found) begin
              status_d       = ovl_pkg::STS_DELETED;
              ctrl.delete_go = 1'b1;
              count_d        = count_q - CntW'(1);
            end else begin
              status_d = ovl_pkg::STS_NOT_FOUND;
            end
          end
          default: begin
            if (found) begin
              status_d = ovl_pkg::STS_FOUND;
              pos_d    = hit_pos;
            end else begin
              status_d = ovl_pkg::STS_NOT_FOUND;
            end
          end
        endcase
      end
      default: begin
        state_d = ovl_pkg::ST_IDLE;
      end
    endcase
  end

  // The count register already holds the count after the request.
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign position_o    = ovl_pkg::PosW'(pos_q);
  assign entry_count_o = ovl_pkg::CountW'(count_q);

endmodule

// ----- hw/rtl/ovl_cell.sv -----
// One storage cell of the ordered value list chain.
// Holds one entry, compares it with the broadcast key and takes its younger
// neighbor's entry when a delete closes the gap. Depends on ovl_pkg.
`timescale 1ns / 1ps

module ovl_cell (
  input  logic                        clk_i,
  input  ovl_pkg::cell_ctrl_t         ctrl_i,
  input  logic                        occupied_i,
  input  logic                        tail_i,
  input  logic                        match_before_i,
  input  logic [ovl_pkg::ValueW-1:0]  next_value_i,
  output logic [ovl_pkg::ValueW-1:0]  value_o,
  output logic                        match_before_o,
  output logic                        first_hit_o
);

  logic [ovl_pkg::ValueW-1:0] value_q, value_d;
  logic                       hit;

  // A match counts only on an entry that holds a written value.
  assign hit            = occupied_i && (value_q == ctrl_i.key);
  assign first_hit_o    = hit && !match_before_i;
  assign match_before_o = match_before_i || hit;

  // Append writes the tail cell; a delete shifts every cell from the match on.
  always_comb begin
    value_d = value_q;
    if (ctrl_i.append_go && tail_i) begin
      value_d = ctrl_i.key;
    end else if (ctrl_i.delete_go && match_before_o) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ----- hw/rtl/ovl_checker.sv -----
// Port-level checks for the ordered value list and the bind that attaches
// them to the top level. Depends on ovl_pkg and ordered_value_list.
`timescale 1ns / 1ps

module ovl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [ovl_pkg::StatusW-1:0]  status_o,
  input logic [ovl_pkg::PosW-1:0]     position_o,
  input logic [ovl_pkg::CountW-1:0]   entry_count_o
);

  // A result waiting for the sink keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(position_o) && $stable(entry_count_o))
    else $error("result changed while stalled");

  // Only one item is in work: no second item right after an accepted one.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in work");

  // A new result is valid once its item has passed the execute state.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 out_valid_o)
    else $error("result did not appear two cycles after its item");

  // Only a successful search reports a position.
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ovl_pkg::STS_FOUND) == (position_o != '0)))
    else $error("position does not agree with status");

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .position_o    (position_o),
  .entry_count_o (entry_count_o)
);
